FILE: src/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg: shared types and constants of the greedy CTC decoder
// Payload structs, sizes, sequencer states and the exp table.
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int MAX_CLASSES    = 64;
    localparam int MAX_TIMESTEPS  = 128;
    localparam int EXP_TABLE_BITS = 10;
    localparam int EXP_SIZE       = 1 << EXP_TABLE_BITS;
    localparam int IDX_W          = $clog2(MAX_CLASSES);
    localparam int CNT_W          = $clog2(MAX_CLASSES + 2);
    localparam int ROW_W          = $clog2(MAX_TIMESTEPS + 1);

    localparam logic [0:0] CFG_BLANK  = 1'b0;
    localparam logic [0:0] CFG_NCLASS = 1'b1;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_LENGTH   = 2'd1;
    localparam logic [1:0] ERR_TIMESTEP = 2'd2;

    typedef struct packed {
        logic signed [15:0] logit;
        logic               last_in_row;
        logic               last_in_sequence;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [5:0]  char_index;
        logic [15:0] probability;
        logic [15:0] mean_confidence;
        logic [7:0]  char_count;
        logic [1:0]  error;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_CLOSE,
        ST_SUM_READ,
        ST_SUM_ACC,
        ST_DIV,
        ST_CHAR,
        ST_CHAR_OUT,
        ST_MEAN,
        ST_SUMMARY_OUT
    } state_t;

    // 2^(-j/2^B) in Q1.16, Taylor series with floored Q0.32 terms
    function automatic logic [16:0] exp_entry(input int j);
        logic [63:0] u, term, acc;
        u    = (64'(j) * 64'd2977044472) >> EXP_TABLE_BITS;
        term = 64'd1 << 32;
        acc  = term;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * u) >> 32) / 64'(k);
            if (k % 2 == 1) acc = acc - term;
            else acc = acc + term;
        end
        return 17'((acc + 64'd32768) >> 16);
    endfunction

    typedef logic [16:0] exp_rom_t [EXP_SIZE];

    function automatic exp_rom_t build_exp_rom();
        exp_rom_t r;
        for (int j = 0; j < EXP_SIZE; j++) r[j] = exp_entry(j);
        return r;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

FILE: src/greedy_ctc_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_ctc_decoder: greedy best-path CTC decoder
// Takes one Q8.8 class logit per s_ transfer, a timestep row at a time. At row
// end it walks the buffered row once to sum exp(x - max) with a shared exp
// unit, divides 2^32 by the sum with a bit-serial divider and emits
// a character result on m_ when the best class is not blank and differs from
// the previous row. On last_in_sequence a summary follows with the character
// count, the mean confidence (a second 24-bit serial divide) and error code.
// Each logit of a row is taken in one cycle while collecting. A row end keeps
// s_ready low while the row is summed and divided and until any character
// is taken; a dropped row passes only the close state; a sequence end waits
// for the summary too. A result waits in the output register while m_ready is low
// and the block holds until it is taken. Reset (aresetn low, synchronous)
// restores the blank class 0 and the class count 37 and clears all sequence
// state. The row buffer holds no reset value; only entries written this row
// are read. Configuration writes (cfg_we, cfg_index, cfg_data) apply at once.
// ----------------------------------------------------------------------------
module greedy_ctc_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  gcd_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output gcd_pkg::out_item_t m_data
);

    gcd_pkg::state_t state_reg, state_next;

    logic [5:0] blank_reg;
    logic [6:0] ccount_reg;

    logic signed [15:0] row_mem [gcd_pkg::MAX_CLASSES];
    logic signed [15:0] rd_reg;

    logic signed [15:0] max_reg, max_next;
    logic [gcd_pkg::IDX_W-1:0] best_reg, best_next;
    logic [gcd_pkg::CNT_W-1:0] eidx_reg, eidx_next;
    logic [gcd_pkg::CNT_W-1:0] len_reg, len_next;
    logic [gcd_pkg::IDX_W-1:0] prev_reg, prev_next;
    logic prev_valid_reg, prev_valid_next;
    logic [gcd_pkg::ROW_W-1:0] rows_reg, rows_next;
    logic [23:0] total_reg, total_next;
    logic [7:0] emitted_reg, emitted_next;
    logic [1:0] eflags_reg, eflags_next;
    logic end_seq_reg, end_seq_next;

    logic [gcd_pkg::CNT_W-1:0] walk_reg, walk_next;
    logic [31:0] sum_reg, sum_next;

    logic [32:0] num_reg, num_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] den_reg, den_next;
    logic [5:0] step_reg, step_next;
    logic div_run_reg, div_run_next;

    logic [15:0] prob_reg, prob_next;
    gcd_pkg::out_item_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic s_fire, m_fire, end_row;
    logic [gcd_pkg::IDX_W-1:0] wr_idx;

    logic [16:0] diff;
    logic [33:0] y;
    logic [16:0] tab;
    logic [31:0] term;
    logic [33:0] rem_try;

    assign s_ready = (state_reg == gcd_pkg::ST_COLLECT);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign m_fire  = out_valid_reg && m_ready;
    assign end_row = s_data.last_in_row || s_data.last_in_sequence;
    assign wr_idx  = eidx_reg[gcd_pkg::IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_reg  <= 6'd0;
            ccount_reg <= 7'd37;
        end else if (cfg_we) begin
            case (cfg_index)
                gcd_pkg::CFG_BLANK:  blank_reg  <= cfg_data[5:0];
                gcd_pkg::CFG_NCLASS: ccount_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && eidx_reg < gcd_pkg::CNT_W'(gcd_pkg::MAX_CLASSES))
            row_mem[wr_idx] <= s_data.logit;
        rd_reg <= row_mem[walk_reg[gcd_pkg::IDX_W-1:0]];
    end

    // shared exp unit
    always_comb begin
        diff = 17'({max_reg[15], max_reg}) - 17'({rd_reg[15], rd_reg});
        y    = 34'(diff) * 34'd94548;
        tab  = gcd_pkg::EXP_ROM[y[23 -: gcd_pkg::EXP_TABLE_BITS]];
        term = (y[33:24] >= 10'd32) ? 32'd0 : 32'(tab >> y[28:24]);
    end

    assign rem_try = {rem_reg, num_reg[32]} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gcd_pkg::ST_COLLECT;
            max_reg        <= '0;
            best_reg       <= '0;
            eidx_reg       <= '0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            rows_reg       <= '0;
            total_reg      <= '0;
            emitted_reg    <= '0;
            eflags_reg     <= '0;
            out_valid_reg  <= 1'b0;
            div_run_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            max_reg        <= max_next;
            best_reg       <= best_next;
            eidx_reg       <= eidx_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            rows_reg       <= rows_next;
            total_reg      <= total_next;
            emitted_reg    <= emitted_next;
            eflags_reg     <= eflags_next;
            out_valid_reg  <= out_valid_next;
            div_run_reg    <= div_run_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg     <= len_next;
        end_seq_reg <= end_seq_next;
        walk_reg    <= walk_next;
        sum_reg     <= sum_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        step_reg    <= step_next;
        prob_reg    <= prob_next;
        out_reg     <= out_next;
    end

    always_comb begin
        state_next      = state_reg;
        max_next        = max_reg;
        best_next       = best_reg;
        eidx_next       = eidx_reg;
        len_next        = len_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        rows_next       = rows_reg;
        total_next      = total_reg;
        emitted_next    = emitted_reg;
        eflags_next     = eflags_reg;
        end_seq_next    = end_seq_reg;
        walk_next       = walk_reg;
        sum_next        = sum_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        step_next       = step_reg;
        div_run_next    = div_run_reg;
        prob_next       = prob_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_ready;

        // shared serial divider: num / den, up to 33 quotient bits
        if (div_run_reg) begin
            if (!rem_try[33]) begin
                rem_next = rem_try[32:0];
                num_next = {num_reg[31:0], 1'b1};
            end else begin
                rem_next = {rem_reg[31:0], num_reg[32]};
                num_next = {num_reg[31:0], 1'b0};
            end
            step_next = step_reg - 6'd1;
            if (step_reg == 6'd1) div_run_next = 1'b0;
        end

        case (state_reg)
            gcd_pkg::ST_COLLECT: begin
                if (s_fire) begin
                    if (eidx_reg < gcd_pkg::CNT_W'(gcd_pkg::MAX_CLASSES)) begin
                        if (eidx_reg == '0 || s_data.logit > max_reg) begin
                            max_next  = s_data.logit;
                            best_next = wr_idx;
                        end
                    end
                    if (eidx_reg <= gcd_pkg::CNT_W'(gcd_pkg::MAX_CLASSES))
                        eidx_next = eidx_reg + 1'b1;
                    if (end_row) begin
                        len_next     = eidx_next;
                        eidx_next    = '0;
                        end_seq_next = s_data.last_in_sequence;
                        state_next   = gcd_pkg::ST_CLOSE;
                    end
                end
            end
            gcd_pkg::ST_CLOSE: begin
                walk_next = '0;
                sum_next  = '0;
                if (rows_reg >= gcd_pkg::ROW_W'(gcd_pkg::MAX_TIMESTEPS)) begin
                    eflags_next[1] = 1'b1;
                    state_next = end_seq_reg ? gcd_pkg::ST_MEAN : gcd_pkg::ST_COLLECT;
                end else begin
                    rows_next = rows_reg + 1'b1;
                    if (len_reg != gcd_pkg::CNT_W'(ccount_reg) ||
                        len_reg > gcd_pkg::CNT_W'(gcd_pkg::MAX_CLASSES)) begin
                        eflags_next[0] = 1'b1;
                        state_next = end_seq_reg ? gcd_pkg::ST_MEAN
                                                 : gcd_pkg::ST_COLLECT;
                    end else begin
                        state_next = gcd_pkg::ST_SUM_READ;
                    end
                end
            end
            gcd_pkg::ST_SUM_READ: begin
                state_next = gcd_pkg::ST_SUM_ACC;
            end
            gcd_pkg::ST_SUM_ACC: begin
                sum_next  = sum_reg + term;
                walk_next = walk_reg + 1'b1;
                if (walk_reg + 1'b1 == len_reg) begin
                    state_next   = gcd_pkg::ST_DIV;
                    num_next     = 33'h1_0000_0000;
                    rem_next     = '0;
                    den_next     = {1'b0, sum_next};
                    step_next    = 6'd33;
                    div_run_next = 1'b1;
                end else begin
                    state_next = gcd_pkg::ST_SUM_READ;
                end
            end
            gcd_pkg::ST_DIV: begin
                if (!div_run_reg) begin
                    if (den_reg == '0 || num_reg > 33'd65535) prob_next = 16'hFFFF;
                    else prob_next = num_reg[15:0];
                    state_next = gcd_pkg::ST_CHAR;
                end
            end
            gcd_pkg::ST_CHAR: begin
                prev_next       = best_reg;
                prev_valid_next = 1'b1;
                if (gcd_pkg::IDX_W'(blank_reg) != best_reg &&
                    !(prev_valid_reg && best_reg == prev_reg)) begin
                    out_next.kind            = gcd_pkg::KIND_CHAR;
                    out_next.char_index      = (best_reg < blank_reg) ? best_reg
                                                                      : best_reg - 1'b1;
                    out_next.probability     = prob_reg;
                    out_next.mean_confidence = '0;
                    out_next.char_count      = '0;
                    out_next.error           = gcd_pkg::ERR_NONE;
                    out_next.last            = !end_seq_reg;
                    out_valid_next           = 1'b1;
                    total_next               = total_reg + 24'(prob_reg);
                    emitted_next             = emitted_reg + 1'b1;
                    state_next               = gcd_pkg::ST_CHAR_OUT;
                end else begin
                    state_next = end_seq_reg ? gcd_pkg::ST_MEAN : gcd_pkg::ST_COLLECT;
                end
            end
            gcd_pkg::ST_CHAR_OUT: begin
                if (m_fire)
                    state_next = end_seq_reg ? gcd_pkg::ST_MEAN : gcd_pkg::ST_COLLECT;
            end
            gcd_pkg::ST_MEAN: begin
                num_next     = {total_reg, 9'd0};
                rem_next     = '0;
                den_next     = 33'(emitted_reg);
                step_next    = 6'd24;
                div_run_next = 1'b1;
                state_next   = gcd_pkg::ST_SUMMARY_OUT;
            end
            gcd_pkg::ST_SUMMARY_OUT: begin
                if (!div_run_reg && !out_valid_reg) begin
                    out_next.kind            = gcd_pkg::KIND_SUMMARY;
                    out_next.char_index      = '0;
                    out_next.probability     = '0;
                    out_next.mean_confidence = (emitted_reg == 8'd0) ? 16'd0
                                                                     : num_reg[15:0];
                    out_next.char_count      = emitted_reg;
                    out_next.error           = eflags_reg[0] ? gcd_pkg::ERR_LENGTH :
                                               eflags_reg[1] ? gcd_pkg::ERR_TIMESTEP :
                                                               gcd_pkg::ERR_NONE;
                    out_next.last            = 1'b1;
                    out_valid_next           = 1'b1;
                    prev_next                = '0;
                    prev_valid_next          = 1'b0;
                    rows_next                = '0;
                    total_next               = '0;
                    emitted_next             = '0;
                    eflags_next              = '0;
                    state_next               = gcd_pkg::ST_CHAR_OUT;
                    end_seq_next             = 1'b0;
                end
            end
            default: state_next = gcd_pkg::ST_COLLECT;
        endcase
    end

    a_ready_only_collect: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_run_reg)
        else $error("divider busy while accepting logits");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");
    a_char_not_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == gcd_pkg::KIND_CHAR) |-> m_data.error == gcd_pkg::ERR_NONE)
        else $error("character result carries an error code");

endmodule
